### rtl/core/jsv_pkg.sv
package jsv_pkg;

   // marker bytes
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_QUOTE    = 8'h22;

   typedef logic [2:0] cls_type;

   localparam cls_type CLS_OTHER    = 3'd0;
   localparam cls_type CLS_QUOTE    = 3'd1;
   localparam cls_type CLS_LBRACE   = 3'd2;
   localparam cls_type CLS_LBRACKET = 3'd3;
   localparam cls_type CLS_RBRACE   = 3'd4;
   localparam cls_type CLS_RBRACKET = 3'd5;
   localparam cls_type CLS_COMMA    = 3'd6;
   localparam cls_type CLS_COLON    = 3'd7;

   // classified request held in the queue
   typedef struct packed {
      logic    eof;
      cls_type cls;
   } item_type;

   typedef logic [3:0] state_type;

   localparam state_type ST_INIT       = 4'd0;
   localparam state_type ST_KSTR_BEGIN = 4'd1;
   localparam state_type ST_KSTR_END   = 4'd2;
   localparam state_type ST_VSTR_BEGIN = 4'd3;
   localparam state_type ST_VSTR_END   = 4'd4;
   localparam state_type ST_OBJ_INIT   = 4'd5;
   localparam state_type ST_OBJ_COLON  = 4'd6;
   localparam state_type ST_ARR_INIT   = 4'd7;
   localparam state_type ST_VALUE      = 4'd8;
   localparam state_type ST_NEXT_COMMA = 4'd9;
   localparam state_type ST_DONE       = 4'd10;
   localparam state_type ST_ERROR      = 4'd11;

   typedef logic [3:0] err_type;

   localparam err_type ERR_OK         = 4'd0;
   localparam err_type ERR_VALUE      = 4'd1;
   localparam err_type ERR_OBJECT     = 4'd2;
   localparam err_type ERR_ARRAY      = 4'd3;
   localparam err_type ERR_STRING     = 4'd4;
   localparam err_type ERR_EMPTY      = 4'd5;
   localparam err_type ERR_AFTER_DONE = 4'd6;
   localparam err_type ERR_EOF_OPEN   = 4'd7;
   localparam err_type ERR_OVERFLOW   = 4'd8;

   localparam int DEPTH_W     = 7;
   localparam int QUEUE_DEPTH = 2;

endpackage

### rtl/core/jsv_ram.sv
module jsv_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/jsv_front.sv
module jsv_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  logic              q_full,
   output logic              q_push,
   output jsv_pkg::item_type q_item
);

   import jsv_pkg::*;

   cls_type cls;

   always_comb begin
      unique case (req_tdata)
         CH_QUOTE:    cls = CLS_QUOTE;
         CH_LBRACE:   cls = CLS_LBRACE;
         CH_LBRACKET: cls = CLS_LBRACKET;
         CH_RBRACE:   cls = CLS_RBRACE;
         CH_RBRACKET: cls = CLS_RBRACKET;
         CH_COMMA:    cls = CLS_COMMA;
         CH_COLON:    cls = CLS_COLON;
         default:     cls = CLS_OTHER;
      endcase
   end

   assign req_tready = ~q_full;
   assign q_push     = req_tvalid & ~q_full;
   assign q_item.eof = req_tlast;
   assign q_item.cls = cls;

endmodule

### rtl/core/jsv_queue.sv
module jsv_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jsv_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output jsv_pkg::item_type pop_item
);

   import jsv_pkg::*;

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/jsv_back.sv
module jsv_back #(
   parameter int MAX_NESTING = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  jsv_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata
);

   import jsv_pkg::*;

   localparam int CNT_W  = $clog2(MAX_NESTING + 1);
   localparam int ADDR_W = $clog2(MAX_NESTING);

   state_type          state_ff, state_in;
   err_type            err_ff, err_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               top_ff, top_in;
   logic               fwd_sel_ff, fwd_sel_in;
   logic               fwd_val_ff, fwd_val_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;

   logic               step;
   logic               do_push, do_pop, push_kind;
   err_type            code;
   logic               second;
   logic               ram_q;
   logic               ram_wr_en;
   logic [CNT_W-1:0]   wr_pos, rd_pos;
   state_type          out_state;
   logic               stack_full;

   // top of stack sits in top_ff; entries below it live in the RAM, and
   // the entry just under the top is read ahead every cycle
   assign second     = fwd_sel_ff ? fwd_val_ff : ram_q;
   assign stack_full = (count_ff >= CNT_W'(MAX_NESTING));
   assign step       = q_valid & (~rsp_valid_ff | rsp_tready);
   assign q_pop      = step;

   always_comb begin
      state_in  = state_ff;
      err_in    = err_ff;
      count_in  = count_ff;
      top_in    = top_ff;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      push_kind = 1'b0;
      code      = ERR_OK;
      if (step && err_ff == ERR_OK) begin
         if (q_item.eof) begin
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               code = ERR_EOF_OPEN;
            end
         end else begin
            unique case (state_ff)
               ST_INIT, ST_OBJ_COLON, ST_ARR_INIT: begin
                  priority if (q_item.cls == CLS_QUOTE) begin
                     state_in = ST_VSTR_BEGIN;
                  end else if (q_item.cls == CLS_LBRACE ||
                               q_item.cls == CLS_LBRACKET) begin
                     if (stack_full) begin
                        code = ERR_OVERFLOW;
                     end else begin
                        do_push   = 1'b1;
                        push_kind = (q_item.cls == CLS_LBRACKET);
                        state_in  = push_kind ? ST_ARR_INIT : ST_OBJ_INIT;
                     end
                  end else if (q_item.cls == CLS_OTHER) begin
                     state_in = ST_VALUE;
                  end else if (state_ff == ST_ARR_INIT &&
                               q_item.cls == CLS_RBRACKET) begin
                     do_pop = 1'b1;
                  end else if (state_ff == ST_ARR_INIT) begin
                     code = ERR_ARRAY;
                  end else begin
                     code = ERR_VALUE;
                  end
               end
               ST_OBJ_INIT: begin
                  priority if (q_item.cls == CLS_QUOTE) begin
                     state_in = ST_KSTR_BEGIN;
                  end else if (q_item.cls == CLS_RBRACE) begin
                     do_pop = 1'b1;
                  end else begin
                     code = ERR_OBJECT;
                  end
               end
               ST_KSTR_BEGIN: begin
                  if (q_item.cls == CLS_QUOTE) begin
                     state_in = ST_KSTR_END;
                  end else begin
                     code = ERR_STRING;
                  end
               end
               ST_VSTR_BEGIN: begin
                  if (q_item.cls == CLS_QUOTE) begin
                     state_in = ST_VSTR_END;
                  end else begin
                     code = ERR_STRING;
                  end
               end
               ST_KSTR_END: begin
                  if (q_item.cls == CLS_COLON) begin
                     state_in = ST_OBJ_COLON;
                  end else begin
                     code = ERR_OBJECT;
                  end
               end
               ST_VSTR_END, ST_VALUE, ST_NEXT_COMMA: begin
                  priority if (count_ff == '0) begin
                     code = ERR_EMPTY;
                  end else if (q_item.cls == CLS_COMMA) begin
                     state_in = top_ff ? ST_ARR_INIT : ST_OBJ_INIT;
                  end else if ((q_item.cls == CLS_RBRACE && !top_ff) ||
                               (q_item.cls == CLS_RBRACKET && top_ff)) begin
                     do_pop = 1'b1;
                  end else begin
                     code = ERR_OBJECT;
                  end
               end
               default: code = ERR_AFTER_DONE;
            endcase
         end

         if (do_push) begin
            count_in = count_ff + 1'b1;
            top_in   = push_kind;
         end
         if (do_pop) begin
            count_in = (count_ff != '0) ? count_ff - 1'b1 : '0;
            state_in = (count_in == '0) ? ST_DONE : ST_NEXT_COMMA;
            top_in   = second;
         end
         if (code != ERR_OK) begin
            err_in   = code;
            state_in = ST_ERROR;
         end
      end
   end

   // old top spills into the RAM on a push; the read-ahead address is the
   // slot under the new top, so after a push the spilled value is forwarded from fwd_val_ff
   assign ram_wr_en  = do_push & (count_ff != '0);
   assign wr_pos     = count_ff - 1'b1;
   assign rd_pos     = count_in - CNT_W'(2);
   assign fwd_sel_in = do_push;
   assign fwd_val_in = do_push ? top_ff : fwd_val_ff;

   jsv_ram #(
      .WIDTH (1),
      .DEPTH (MAX_NESTING)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_pos[ADDR_W-1:0]),
      .wr_data (top_ff),
      .rd_addr (rd_pos[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   assign out_state = (err_in != ERR_OK) ? ST_ERROR : state_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(out_state == ST_DONE), DEPTH_W'(count_in), out_state, err_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         err_ff       <= ERR_OK;
         count_ff     <= '0;
         fwd_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         count_ff     <= count_in;
         fwd_sel_ff   <= fwd_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      fwd_val_ff  <= fwd_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_NESTING))
      else $error("stack depth beyond limit");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      err_ff != ERR_OK |=> err_ff == $past(err_ff) && $stable(count_ff))
      else $error("sticky error or depth changed after error");

   a_error_state: assert property (@(posedge clock) disable iff (reset)
      err_ff != ERR_OK |-> state_ff == ST_ERROR)
      else $error("error held without error state");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(count_ff) && $stable(state_ff))
      else $error("parser state moved without a request");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> count_ff == '0)
      else $error("done with open brackets");

endmodule

### rtl/core/json_structure_validator.sv
// A request accepted at a clock edge is written into the queue at that edge; its response is
// registered when the parser steps on it, and a stall on rsp can hold that step off.
// One request per cycle while rsp is not stalled; each parser step does its stack push or pop,
// the top-of-stack register and a read-ahead port on the stack RAM keep pops at full rate,
// and stalls on rsp back up through a two-entry queue into req_tready.
// Reset (synchronous, active high) empties the queue and clears parser, stack and error.
module json_structure_validator #(
   parameter int MAX_NESTING = 64     // open objects/arrays allowed, 2..127
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] token
   input  logic        req_tlast,     // end_of_input: stream ended, token ignored
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata      // [3:0] error_code, [7:4] parse_state,
                                      // [14:8] nesting_depth, [15] document_done
);

   import jsv_pkg::*;

   item_type fr_item;
   item_type q_item;
   logic     fr_push;
   logic     q_full;
   logic     q_not_empty;
   logic     q_pop;

   // front: accept the request and reduce the byte to a marker class
   jsv_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (fr_push),
      .q_item     (fr_item)
   );

   // short queue decoupling acceptance from the parser
   jsv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_push),
      .push_item (fr_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (q_item)
   );

   // back: pushdown parser, bracket stack, sticky error, response register
   jsv_back #(
      .MAX_NESTING (MAX_NESTING)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### tb/jsv_structure_checker.sv
module jsv_structure_checker #(
   parameter int MAX_NESTING = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] token
   input  logic        req_tlast,    // end_of_input
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,    // [3:0] error_code, [7:4] parse_state,
                                     // [14:8] nesting_depth, [15] document_done
   output int          failures,
   output int          pending
);
   import jsv_pkg::*;

   // same bit order as rsp_tdata
   typedef struct packed {
      logic       done;
      logic [6:0] depth;
      state_type  state;
      err_type    err;
   } parse_report_type;

   parse_report_type expected_reports[$];

   // parser shadow
   state_type pstate;
   logic      open_kind [MAX_NESTING];   // 1 array, 0 object
   int        open_count;
   err_type   first_error;

   function automatic bit is_closer_or_sep(input logic [7:0] t);
      return t == CH_RBRACE || t == CH_RBRACKET || t == CH_COMMA || t == CH_COLON;
   endfunction

   function automatic void close_level();
      if (open_count > 0)
         open_count--;
      pstate = (open_count == 0) ? ST_DONE : ST_NEXT_COMMA;
   endfunction

   // refused: byte cannot start a value at all
   function automatic err_type begin_value(input logic [7:0] t, output bit refused);
      refused = 1'b0;
      if (t == CH_QUOTE) begin
         pstate = ST_VSTR_BEGIN;
      end else if (t == CH_LBRACE || t == CH_LBRACKET) begin
         if (open_count >= MAX_NESTING)
            return ERR_OVERFLOW;
         open_kind[open_count] = (t == CH_LBRACKET);
         open_count++;
         pstate = (t == CH_LBRACE) ? ST_OBJ_INIT : ST_ARR_INIT;
      end else if (!is_closer_or_sep(t)) begin
         pstate = ST_VALUE;
      end else begin
         refused = 1'b1;
      end
      return ERR_OK;
   endfunction

   function automatic err_type step_parser(input logic [7:0] t);
      err_type e;
      bit      refused;
      bit      top_is_array;
      case (pstate)
         ST_INIT, ST_OBJ_COLON: begin
            e = begin_value(t, refused);
            return refused ? ERR_VALUE : e;
         end
         ST_OBJ_INIT: begin
            if (t == CH_QUOTE)
               pstate = ST_KSTR_BEGIN;
            else if (t == CH_RBRACE)
               close_level();
            else
               return ERR_OBJECT;
            return ERR_OK;
         end
         ST_ARR_INIT: begin
            e = begin_value(t, refused);
            if (!refused)
               return e;
            if (t != CH_RBRACKET)
               return ERR_ARRAY;
            close_level();
            return ERR_OK;
         end
         ST_KSTR_BEGIN, ST_VSTR_BEGIN: begin
            if (t != CH_QUOTE)
               return ERR_STRING;
            pstate = (pstate == ST_KSTR_BEGIN) ? ST_KSTR_END : ST_VSTR_END;
            return ERR_OK;
         end
         ST_KSTR_END: begin
            if (t != CH_COLON)
               return ERR_OBJECT;
            pstate = ST_OBJ_COLON;
            return ERR_OK;
         end
         ST_VSTR_END, ST_VALUE, ST_NEXT_COMMA: begin
            if (open_count == 0)
               return ERR_EMPTY;
            top_is_array = open_kind[open_count - 1];
            if (t == CH_COMMA) begin
               pstate = top_is_array ? ST_ARR_INIT : ST_OBJ_INIT;
               return ERR_OK;
            end
            if ((t == CH_RBRACE && !top_is_array) || (t == CH_RBRACKET && top_is_array)) begin
               close_level();
               return ERR_OK;
            end
            return ERR_OBJECT;
         end
         default: return ERR_AFTER_DONE;
      endcase
   endfunction

   // one request in, one report out; the first error freezes everything
   function automatic parse_report_type parse_marker(input logic [7:0] t, input logic eof);
      parse_report_type rpt;
      if (first_error == ERR_OK) begin
         if (!eof)
            first_error = step_parser(t);
         else if (open_count == 0)
            pstate = ST_DONE;
         else
            first_error = ERR_EOF_OPEN;
      end
      rpt.depth = open_count[6:0];
      if (first_error != ERR_OK) begin
         rpt.err   = first_error;
         rpt.state = ST_ERROR;
         rpt.done  = 1'b0;
      end else begin
         rpt.err   = ERR_OK;
         rpt.state = pstate;
         rpt.done  = (pstate == ST_DONE);
      end
      return rpt;
   endfunction

   task automatic check_field(input string field, input int want, input int seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", field, want, seen);
         failures++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      parse_report_type want;
      parse_report_type seen;
      if (reset) begin
         pstate      = ST_INIT;
         open_count  = 0;
         first_error = ERR_OK;
         failures    = 0;
         expected_reports.delete();
      end else begin
         // response side first: a request taken at this edge cannot answer here
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (expected_reports.size() == 0) begin
               $error("response %h with no request outstanding", rsp_tdata);
               failures++;
            end else begin
               want = expected_reports.pop_front();
               check_field("error_code", int'(want.err), int'(seen.err));
               check_field("parse_state", int'(want.state), int'(seen.state));
               check_field("nesting_depth", int'(want.depth), int'(seen.depth));
               check_field("document_done", int'(want.done), int'(seen.done));
            end
         end
         if (req_tvalid && req_tready)
            expected_reports.insert(expected_reports.size(),
                                    parse_marker(req_tdata, req_tlast));
      end
      pending <= expected_reports.size();
   end

endmodule

### tb/json_structure_validator_tb.sv
module json_structure_validator_tb;
   import jsv_pkg::*;

   localparam int NEST_LIMIT   = 64;
   localparam int RANDOM_ITEMS = 900;
   localparam int NOISE_ITEMS  = 20;
   localparam int STALL_LIMIT  = 1000;   // quiet cycles before we call it hung
   localparam int DRAIN_CYCLES = 16;     // idle cycles once no response is pending
   localparam int HOLD_CYCLES  = 80;     // long receiver back-pressure

   // where the generated document stands, from the sender's point of view
   typedef enum int {
      POS_TOP, POS_VALUE_ARR, POS_VALUE_OBJ, POS_KEY, POS_KEY_QUOTE,
      POS_COLON, POS_VSTR, POS_AFTER, POS_DONE
   } grammar_pos_type;

   typedef enum int {GEN_FREE, GEN_DIVE, GEN_CLOSE} gen_mode_type;

   // how the single document of the run is ended; every error sticks
   // until reset, so each run can show only one of these
   typedef enum int {
      END_CLEAN, END_OVERFLOW, END_EOF_OPEN, END_MISMATCH, END_STRING,
      END_ARRAY, END_VALUE, END_KEY, END_NOISE
   } ending_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] token
   logic        req_tlast  = 1'b0;    // end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [3:0] error_code, [7:4] parse_state,
                                      // [14:8] nesting_depth, [15] document_done
   int          failures;
   int          pending;

   // sender-side bookkeeping
   grammar_pos_type gpos = POS_TOP;
   bit              open_kinds[$];    // 1 array, 0 object
   int              sent = 0;

   // receiver-side bookkeeping
   int rsp_beats = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   json_structure_validator #(.MAX_NESTING(NEST_LIMIT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   jsv_structure_checker #(.MAX_NESTING(NEST_LIMIT)) structure_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   // Offer one request and hold it until taken. Ready is read right after the
   // edge, before any update of that edge lands, so it is the value the edge saw.
   // Requests 300..499 go out back to back; elsewhere ~3% get a gap with valid low first.
   task automatic send_request(input logic [7:0] tok, input logic last);
      if (!(sent >= 300 && sent < 500) && $urandom_range(0, 99) < 3) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tok;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // any byte that is neither a bracket, a separator nor a quote
   function automatic logic [7:0] random_scalar();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == CH_LBRACE || b == CH_RBRACE || b == CH_LBRACKET ||
                 b == CH_RBRACKET || b == CH_COMMA || b == CH_COLON || b == CH_QUOTE);
      return b;
   endfunction

   function automatic void pop_level();
      open_kinds.delete(open_kinds.size() - 1);
      gpos = (open_kinds.size() == 0) ? POS_DONE : POS_AFTER;
   endfunction

   // advance the sender's view of the document over a well-formed byte
   function automatic void follow_token(input logic [7:0] tok);
      case (gpos)
         POS_KEY: begin
            if (tok == CH_QUOTE)
               gpos = POS_KEY_QUOTE;
            else
               pop_level();
         end
         POS_KEY_QUOTE: gpos = POS_COLON;
         POS_COLON:     gpos = POS_VALUE_OBJ;
         POS_VSTR:      gpos = POS_AFTER;
         POS_AFTER: begin
            if (tok == CH_COMMA)
               gpos = open_kinds[$] ? POS_VALUE_ARR : POS_KEY;
            else
               pop_level();
         end
         default: begin   // a value may start here
            if (tok == CH_QUOTE) begin
               gpos = POS_VSTR;
            end else if (tok == CH_LBRACE) begin
               open_kinds.insert(open_kinds.size(), 1'b0);
               gpos = POS_KEY;
            end else if (tok == CH_LBRACKET) begin
               open_kinds.insert(open_kinds.size(), 1'b1);
               gpos = POS_VALUE_ARR;
            end else if (tok == CH_RBRACKET) begin
               pop_level();   // empty array or trailing comma
            end else begin
               gpos = POS_AFTER;
            end
         end
      endcase
   endfunction

   // Pick the next well-formed byte. FREE never closes the outer array, so the
   // document stays alive; DIVE opens whenever it can; CLOSE winds everything down.
   function automatic logic [7:0] pick_token(input gen_mode_type mode);
      int         roll;
      int         depth;
      logic [7:0] closer;
      roll   = $urandom_range(0, 99);
      depth  = open_kinds.size();
      closer = (depth > 0 && open_kinds[$]) ? CH_RBRACKET : CH_RBRACE;
      case (gpos)
         POS_KEY_QUOTE, POS_VSTR: return CH_QUOTE;
         POS_COLON:               return CH_COLON;
         POS_KEY: begin
            if (mode == GEN_CLOSE || (mode == GEN_FREE && depth > 1 && roll < 15))
               return CH_RBRACE;
            return CH_QUOTE;
         end
         POS_AFTER: begin
            // deeper levels close more eagerly so depth keeps wandering
            if (mode == GEN_CLOSE || (mode == GEN_FREE && depth > 1 && roll < 10 + 2 * depth))
               return closer;
            return CH_COMMA;
         end
         default: begin
            if (mode == GEN_DIVE && depth < NEST_LIMIT)
               return (roll < 70) ? CH_LBRACKET : CH_LBRACE;
            if (mode == GEN_CLOSE)
               return (gpos == POS_VALUE_ARR) ? CH_RBRACKET : random_scalar();
            if (depth < NEST_LIMIT && roll < (depth < 4 ? 35 : 12))
               return roll[0] ? CH_LBRACKET : CH_LBRACE;
            if (gpos == POS_VALUE_ARR && depth > 1 && roll >= 90)
               return CH_RBRACKET;
            if (roll >= 70)
               return CH_QUOTE;
            return random_scalar();
         end
      endcase
   endfunction

   task automatic push_marker(input logic [7:0] tok);
      send_request(tok, 1'b0);
      follow_token(tok);
   endtask

   // keep the document well formed until it reaches the wanted spot
   task automatic reach(input grammar_pos_type target);
      int guard;
      guard = 0;
      while (gpos != target && guard < 500) begin
         push_marker(pick_token(GEN_FREE));
         guard++;
      end
   endtask

   // receiver: random stalls, one long hold-off after 200 responses while
   // requests keep coming, and a stall-free window over responses 500..649
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         rsp_beats <= rsp_beats + 1;
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_beats == 200) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_beats >= 500 && rsp_beats < 650) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 6);
      end
   end

   // watchdog: too long without any handshake on either side
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("json_structure_validator_tb: errors");
      $finish;
   end

   initial begin : stimulus
      ending_type ending;
      bit         diving;
      int         n;
      ending = ending_type'($urandom_range(0, 8));
      diving = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed opening: outer array holding an empty object, an empty array,
      // a string, an object with a trailing comma and extreme scalar byte,
      // an array with a trailing comma and the zero byte
      push_marker(CH_LBRACKET);
      push_marker(CH_LBRACE);
      push_marker(CH_RBRACE);
      push_marker(CH_COMMA);
      push_marker(CH_LBRACKET);
      push_marker(CH_RBRACKET);
      push_marker(CH_COMMA);
      push_marker(CH_QUOTE);
      push_marker(CH_QUOTE);
      push_marker(CH_COMMA);
      push_marker(CH_LBRACE);
      push_marker(CH_QUOTE);
      push_marker(CH_QUOTE);
      push_marker(CH_COLON);
      push_marker(8'hFF);
      push_marker(CH_COMMA);
      push_marker(CH_RBRACE);
      push_marker(CH_COMMA);
      push_marker(CH_LBRACKET);
      push_marker(8'h00);
      push_marker(CH_COMMA);
      push_marker(CH_RBRACKET);
      push_marker(CH_COMMA);

      // random well-formed content, with one dive to the nesting limit
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 400)
            diving = 1'b1;
         if (diving && open_kinds.size() == NEST_LIMIT)
            diving = 1'b0;
         push_marker(pick_token(diving ? GEN_DIVE : GEN_FREE));
      end

      case (ending)
         END_CLEAN: begin
            // close everything, end of input twice, then a byte past the end
            while (gpos != POS_DONE)
               push_marker(pick_token(GEN_CLOSE));
            send_request(8'($urandom_range(0, 255)), 1'b1);
            send_request(8'($urandom_range(0, 255)), 1'b1);
            send_request(random_scalar(), 1'b0);
         end
         END_OVERFLOW: begin
            while (!(open_kinds.size() == NEST_LIMIT &&
                     (gpos == POS_VALUE_ARR || gpos == POS_VALUE_OBJ)))
               push_marker(pick_token(GEN_DIVE));
            send_request($urandom_range(0, 1) ? CH_LBRACKET : CH_LBRACE, 1'b0);
         end
         END_EOF_OPEN: send_request(8'($urandom_range(0, 255)), 1'b1);
         END_MISMATCH: begin
            reach(POS_AFTER);
            send_request(open_kinds[$] ? CH_RBRACE : CH_RBRACKET, 1'b0);
         end
         END_STRING: begin
            reach(POS_VSTR);
            send_request(random_scalar(), 1'b0);
         end
         END_ARRAY: begin
            reach(POS_VALUE_ARR);
            send_request(CH_COLON, 1'b0);
         end
         END_VALUE: begin
            reach(POS_VALUE_OBJ);
            send_request(CH_COMMA, 1'b0);
         end
         END_KEY: begin
            reach(POS_KEY);
            send_request(random_scalar(), 1'b0);
         end
         default: ;
      endcase

      // raw noise: after an error the block must hold it; otherwise it errors here
      repeat (NOISE_ITEMS)
         send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      req_tvalid <= 1'b0;

      // let the last request reach the scoreboard, then drain
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("json_structure_validator_tb: clean");
      else
         $display("json_structure_validator_tb: errors");
      $finish;
   end

endmodule

### filelist.f
rtl/core/jsv_pkg.sv
rtl/core/jsv_ram.sv
rtl/core/jsv_front.sv
rtl/core/jsv_queue.sv
rtl/core/jsv_back.sv
rtl/core/json_structure_validator.sv
tb/jsv_structure_checker.sv
tb/json_structure_validator_tb.sv
